// ----- rtl/dtw_pkg.sv -----
// dtw_pkg: shared sizes and the wavefront item type for the DTW distance block.
// Used by dtw_cell, dtw_distance and the testbench files; depends on nothing else.
`timescale 1ns / 1ps

package dtw_pkg;

    localparam int MAX_LEN     = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COST_BITS   = 32;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int IDX_BITS    = $clog2(MAX_LEN);
    localparam int CNT_BITS    = $clog2(MAX_LEN + 1);

    localparam logic [COST_BITS-1:0] COST_CEIL = '1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAND = 1'b1;

    // One candidate sample travelling down the row of cells
    typedef struct packed {
        logic                          valid;
        logic                          act;    // still has cells to update
        logic                          head;   // next cell is column 0
        logic                          first;  // first sample of a candidate
        logic                          last;   // last sample: carries the result
        logic                          sat;    // saturation seen so far
        logic [IDX_BITS-1:0]           rem;    // cells left after the next one
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [COST_BITS-1:0]          above;  // new cost of previous cell
        logic [COST_BITS-1:0]          diag;   // old cost of previous cell
    } token_t;

endpackage

// ----- rtl/dtw_cell.sv -----
// dtw_cell: one column of the DTW cost row; holds a query sample and its cost.
// Depends on dtw_pkg.
`timescale 1ns / 1ps

module dtw_cell
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_wr,
    input  logic signed [dtw_pkg::SAMPLE_BITS-1:0] q_data,
    input  dtw_pkg::token_t                        tok_in,
    output dtw_pkg::token_t                        tok_out
);

    logic signed [dtw_pkg::SAMPLE_BITS-1:0] q_reg;
    logic [dtw_pkg::COST_BITS-1:0]          cost_reg;
    logic [dtw_pkg::COST_BITS-1:0]          cost_next;
    logic                                   sticky_reg;
    logic                                   sticky_next;
    dtw_pkg::token_t                        tok_reg;
    dtw_pkg::token_t                        tok_next;

    logic signed [dtw_pkg::DIFF_BITS-1:0] diff;
    logic [dtw_pkg::DIFF_BITS-1:0]        mag;
    logic [dtw_pkg::COST_BITS-1:0]        min_ab;
    logic [dtw_pkg::COST_BITS-1:0]        min3;
    logic [dtw_pkg::COST_BITS-1:0]        best;
    logic [dtw_pkg::COST_BITS:0]          sum;
    logic                                 sat_now;
    logic                                 proc;

    assign proc = tok_in.valid && tok_in.act;

    always_comb
    begin
        diff = $signed({q_reg[dtw_pkg::SAMPLE_BITS-1], q_reg})
             - $signed({tok_in.sample[dtw_pkg::SAMPLE_BITS-1], tok_in.sample});
        mag  = diff[dtw_pkg::DIFF_BITS-1] ? dtw_pkg::DIFF_BITS'(-diff)
                                          : dtw_pkg::DIFF_BITS'(diff);
    end

    always_comb
    begin
        min_ab = (tok_in.above < cost_reg) ? tok_in.above : cost_reg;
        min3   = (min_ab < tok_in.diag) ? min_ab : tok_in.diag;
        if (tok_in.first)
            best = tok_in.above;        // first sample: running sum across the columns
        else if (tok_in.head)
            best = cost_reg;            // column 0: only the left neighbor
        else
            best = min3;
        sum     = {1'b0, best} + (dtw_pkg::COST_BITS + 1)'(mag);
        sat_now = (sum >= {1'b0, dtw_pkg::COST_CEIL});
    end

    always_comb
    begin
        cost_next   = cost_reg;
        sticky_next = sticky_reg;
        tok_next    = tok_in;
        if (proc)
        begin
            cost_next      = sat_now ? dtw_pkg::COST_CEIL : sum[dtw_pkg::COST_BITS-1:0];
            sticky_next    = tok_in.first ? sat_now : (sticky_reg | sat_now);
            tok_next.above = cost_next;
            tok_next.diag  = cost_reg;
            tok_next.head  = 1'b0;
            tok_next.sat   = tok_in.sat | sat_now | (sticky_reg & ~tok_in.first);
            if (tok_in.rem == '0)
            begin
                // final column done: only a closing sample travels on
                tok_next.act   = 1'b0;
                tok_next.valid = tok_in.last;
            end
            else
            begin
                tok_next.rem = tok_in.rem - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            q_reg <= q_data;
        cost_reg <= cost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            sticky_reg <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            sticky_reg <= sticky_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/dtw_distance.sv -----
// dtw_distance: top level of the DTW distance engine, a row of dtw_cell columns.
// Depends on dtw_pkg and dtw_cell.
`timescale 1ns / 1ps

//  channel  | ports                             | handshake
//  ---------+-----------------------------------+----------------------------------
//  item in  | command, sample, last             | taken when start && !busy
//  result   | distance, saturated               | result_valid, one cycle, no stall
//
//  A candidate item is taken every cycle while busy is low; it enters a
//  register and then walks the row of MAX_LEN cells, one cell per cycle, as
//  a skewed wavefront. Its result is on the outputs once it leaves the last
//  cell. A load item is written straight into its cell when the row is empty.
//  A load that follows candidates is parked and busy stays high until the
//  row drains, since the query samples sit inside the cells.
//  Reset clears the control state; query samples and costs are undefined
//  until written. The receiver cannot stall results.

module dtw_distance
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   command,
    input  logic signed [dtw_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   last,
    output logic                                   result_valid,
    output logic [dtw_pkg::COST_BITS-1:0]          distance,
    output logic                                   saturated
);

    localparam int N = dtw_pkg::MAX_LEN;

    logic [dtw_pkg::CNT_BITS-1:0]           load_pos_reg;
    logic [dtw_pkg::CNT_BITS-1:0]           load_pos_next;
    logic [dtw_pkg::CNT_BITS-1:0]           qc_reg;
    logic [dtw_pkg::CNT_BITS-1:0]           qc_next;
    logic                                   first_reg;
    logic                                   first_next;
    logic                                   hold_valid_reg;
    logic                                   hold_valid_next;
    logic signed [dtw_pkg::SAMPLE_BITS-1:0] hold_sample_reg;
    logic                                   hold_last_reg;
    dtw_pkg::token_t                        inj_reg;
    dtw_pkg::token_t                        inj_next;

    dtw_pkg::token_t                        tok [N+1];
    logic [N-1:0]                           tok_valid;
    logic [N-1:0]                           wr_vec;

    logic                                   accept;
    logic                                   pipe_empty;
    logic                                   ld_go;
    logic signed [dtw_pkg::SAMPLE_BITS-1:0] ld_sample;
    logic                                   ld_last;
    logic                                   ld_store;

    assign busy       = hold_valid_reg;
    assign accept     = start && !busy;
    assign pipe_empty = !inj_reg.valid && (tok_valid == '0);

    // Load path: a parked load goes first, else a fresh one if the row is empty
    always_comb
    begin
        ld_go     = 1'b0;
        ld_sample = sample;
        ld_last   = last;
        if (hold_valid_reg)
        begin
            ld_go     = pipe_empty;
            ld_sample = hold_sample_reg;
            ld_last   = hold_last_reg;
        end
        else if (accept && command == dtw_pkg::CMD_LOAD)
        begin
            ld_go = pipe_empty;
        end
    end

    assign ld_store = ld_go && (load_pos_reg < dtw_pkg::CNT_BITS'(N));

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg && pipe_empty)
            hold_valid_next = 1'b0;
        else if (accept && command == dtw_pkg::CMD_LOAD && !pipe_empty)
            hold_valid_next = 1'b1;
    end

    always_comb
    begin
        load_pos_next = load_pos_reg;
        qc_next       = qc_reg;
        first_next    = first_reg;
        inj_next      = '0;
        if (ld_go)
        begin
            if (load_pos_reg == '0)
            begin
                qc_next    = '0;      // new query drops the old one
                first_next = 1'b1;
            end
            if (ld_store)
                load_pos_next = load_pos_reg + 1'b1;
            if (ld_last)
            begin
                qc_next       = load_pos_next;
                load_pos_next = '0;
            end
        end
        else if (accept && command == dtw_pkg::CMD_CAND && qc_reg != '0)
        begin
            inj_next.valid  = 1'b1;
            inj_next.act    = 1'b1;
            inj_next.head   = 1'b1;
            inj_next.first  = first_reg;
            inj_next.last   = last;
            inj_next.sat    = 1'b0;
            inj_next.rem    = dtw_pkg::IDX_BITS'(qc_reg - 1'b1);
            inj_next.sample = sample;
            inj_next.above  = '0;
            inj_next.diag   = '0;
            first_next      = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg   <= '0;
            qc_reg         <= '0;
            first_reg      <= 1'b1;
            hold_valid_reg <= 1'b0;
            inj_reg        <= '0;
        end
        else
        begin
            load_pos_reg   <= load_pos_next;
            qc_reg         <= qc_next;
            first_reg      <= first_next;
            hold_valid_reg <= hold_valid_next;
            inj_reg        <= inj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == dtw_pkg::CMD_LOAD && !pipe_empty && !hold_valid_reg)
        begin
            hold_sample_reg <= sample;
            hold_last_reg   <= last;
        end
    end

    // Row of cells; cell k holds query sample k and cost column k
    assign tok[0] = inj_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        assign wr_vec[k] = ld_store &&
                           (load_pos_reg[dtw_pkg::IDX_BITS-1:0] == dtw_pkg::IDX_BITS'(k));

        dtw_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .q_wr    (wr_vec[k]),
            .q_data  (ld_sample),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );

        assign tok_valid[k] = tok[k+1].valid;
    end

    // Only closing samples leave the row, carrying the final cell cost
    assign result_valid = tok[N].valid && tok[N].last;
    assign distance     = tok[N].above;
    assign saturated    = tok[N].sat;

    // Query samples are never rewritten under a moving wavefront
    a_wr_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_vec != '0) |-> pipe_empty)
        else $error("query write while row busy");

    // A parked load is released as soon as the row drains
    a_hold_release: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && pipe_empty) |=> !hold_valid_reg)
        else $error("parked load not released");

    // Candidates only enter with a loaded query
    a_inj_query: assert property (@(posedge clk) disable iff (!rst_n)
        inj_reg.valid |-> (qc_reg != '0))
        else $error("candidate injected without query");

    // A result can only come out while the query that made it is in place
    a_result_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (qc_reg != '0 && !ld_go))
        else $error("result without query");

endmodule

// ----- tb/sv/dtw_distance_checker.sv -----
// dtw_distance_checker: watches the item and result channels of dtw_distance,
// predicts each warping distance and compares it. Depends on dtw_pkg.
`timescale 1ns / 1ps

module dtw_distance_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic                                   command,
    input  logic signed [dtw_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   last,
    input  logic                                   result_valid,
    input  logic [dtw_pkg::COST_BITS-1:0]          distance,
    input  logic                                   saturated,
    output int                                     fail_count,
    output int                                     outstanding,
    output int                                     items_taken,
    output int                                     results_checked
);

    import dtw_pkg::*;

    typedef struct {
        logic [COST_BITS-1:0] distance;
        logic                 saturated;
    } dtw_result_t;

    // Costs are kept two bits wider so the clamp can see the overflow.
    localparam logic [COST_BITS+1:0] CEIL_WIDE = {2'b00, COST_CEIL};

    logic signed [SAMPLE_BITS-1:0] qry_samples [MAX_LEN];
    logic [COST_BITS+1:0]          row_cost    [MAX_LEN];
    logic [CNT_BITS-1:0]           qry_len;
    logic [CNT_BITS-1:0]           load_pos;
    logic                          new_candidate;
    logic                          sat_seen;

    dtw_result_t expected_results [$];

    function automatic logic [COST_BITS+1:0] point_dist(logic signed [SAMPLE_BITS-1:0] a,
                                                       logic signed [SAMPLE_BITS-1:0] b);
        int d;
        d = int'(a) - int'(b);
        if (d < 0)
            d = -d;
        return (COST_BITS+2)'(d);
    endfunction

    function automatic logic [COST_BITS+1:0] cost_add(logic [COST_BITS+1:0] a,
                                                     logic [COST_BITS+1:0] b);
        logic [COST_BITS+1:0] s;
        s = a + b;
        if (s >= CEIL_WIDE)
        begin
            sat_seen = 1'b1;
            return CEIL_WIDE;
        end
        return s;
    endfunction

    task automatic predict_item(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp,
                                input logic lst);
        int                   col;
        logic [COST_BITS+1:0] diag_cost;
        logic [COST_BITS+1:0] left_cost;
        logic [COST_BITS+1:0] best;
        dtw_result_t          res;
        if (cmd == CMD_LOAD)
        begin
            // first load sample drops the old query
            if (load_pos == 0)
            begin
                qry_len       = '0;
                new_candidate = 1'b1;
                sat_seen      = 1'b0;
            end
            if (load_pos < MAX_LEN)
            begin
                qry_samples[load_pos[IDX_BITS-1:0]] = smp;
                load_pos                            = load_pos + 1'b1;
            end
            if (lst)
            begin
                qry_len  = load_pos;
                load_pos = '0;
            end
            return;
        end
        if (qry_len == 0)
            return;
        if (new_candidate)
        begin
            sat_seen    = 1'b0;
            row_cost[0] = cost_add('0, point_dist(qry_samples[0], smp));
            for (col = 1; col < qry_len; col++)
                row_cost[IDX_BITS'(col)] =
                    cost_add(row_cost[IDX_BITS'(col-1)],
                             point_dist(qry_samples[IDX_BITS'(col)], smp));
        end
        else
        begin
            diag_cost   = row_cost[0];
            row_cost[0] = cost_add(row_cost[0], point_dist(qry_samples[0], smp));
            for (col = 1; col < qry_len; col++)
            begin
                left_cost = row_cost[IDX_BITS'(col)];
                best      = row_cost[IDX_BITS'(col-1)];
                if (left_cost < best)
                    best = left_cost;
                if (diag_cost < best)
                    best = diag_cost;
                row_cost[IDX_BITS'(col)] =
                    cost_add(best, point_dist(qry_samples[IDX_BITS'(col)], smp));
                diag_cost = left_cost;
            end
        end
        if (lst)
        begin
            res.distance  = row_cost[IDX_BITS'(qry_len - 1'b1)][COST_BITS-1:0];
            res.saturated = sat_seen;
            expected_results.push_back(res);
            new_candidate = 1'b1;
            sat_seen      = 1'b0;
        end
        else
            new_candidate = 1'b0;
    endtask

    assign outstanding = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        dtw_result_t want;
        if (!rst_n)
        begin
            qry_len         = '0;
            load_pos        = '0;
            new_candidate   = 1'b1;
            sat_seen        = 1'b0;
            fail_count      = 0;
            items_taken     = 0;
            results_checked = 0;
            expected_results.delete();
        end
        else
        begin
            // results first: no item can produce a result in its own cycle
            if (result_valid)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: distance %0d saturated %0d", distance, saturated);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (distance !== want.distance)
                    begin
                        $error("distance: expected %0d, got %0d", want.distance, distance);
                        fail_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d, got %0d", want.saturated, saturated);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                items_taken++;
                predict_item(command, sample, last);
            end
        end
    end

endmodule

// ----- tb/sv/tb_dtw_distance.sv -----
// tb_dtw_distance: stimulus and verdict for the dtw_distance block; the checker
// module beside the block does all prediction. Depends on dtw_pkg, dtw_distance.
`timescale 1ns / 1ps

module tb_dtw_distance;

    import dtw_pkg::*;

    // Even if every item were a reload parked behind a full row, the run
    // would still end well inside this limit.
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int PHASE_ITEMS  = 390;
    localparam int DRAIN_CYCLES = MAX_LEN + 8;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          busy;
    logic                          result_valid;
    logic [COST_BITS-1:0]          distance;
    logic                          saturated;

    int fail_count;
    int outstanding;
    int items_taken;
    int results_checked;
    int items_sent;
    int send_idle_pct;
    int cycle_count;

    dtw_distance i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .distance     (distance),
        .saturated    (saturated)
    );

    dtw_distance_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .sample          (sample),
        .last            (last),
        .result_valid    (result_valid),
        .distance        (distance),
        .saturated       (saturated),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .items_taken     (items_taken),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_dtw_distance: done, errors");
        $finish;
    end

    // Sample values: extremes and tiny values often, full random otherwise.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'($urandom_range(0, 31)) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    // Every task below is entered and left just after a falling edge, so
    // each input gets exactly one assignment per falling edge.
    task automatic send_item(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            // junk on the fields while start is low must be ignored
            start   <= 1'b0;
            command <= 1'($urandom);
            sample  <= 16'($urandom);
            last    <= 1'($urandom);
            @(negedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        sample  <= smp;
        last    <= lst;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        @(negedge clk);
    endtask

    // Sender holds off until every predicted distance has come out.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_query(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(CMD_LOAD, pick_sample(), k == len - 1);
    endtask

    task automatic send_candidate(input int len, input logic closed);
        int k;
        for (k = 0; k < len; k++)
            send_item(CMD_CAND, pick_sample(), closed && (k == len - 1));
    endtask

    function automatic int pick_query_len();
        int r;
        r = $urandom_range(99);
        if (r < 72)
            return $urandom_range(1, 8);
        if (r < 80)
            return MAX_LEN;
        if (r < 95)
            return $urandom_range(9, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, MAX_LEN + 8);  // overlong, tail dropped
    endfunction

    function automatic int pick_cand_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 10);
        return $urandom_range(11, 80);
    endfunction

    task automatic run_random(input int n_items);
        int target;
        int r;
        int n;
        int k;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                // well-formed: query then a few closed candidates
                send_query(pick_query_len());
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_candidate(pick_cand_len(), 1'b1);
            end
            else if (r < 80)
            begin
                // candidate cut short by a fresh query
                send_query(pick_query_len());
                send_candidate(pick_cand_len(), 1'b0);
            end
            else if (r < 90)
            begin
                // open query: candidates in between are ignored
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_item(CMD_LOAD, pick_sample(), 1'b0);
                send_candidate($urandom_range(1, 3), 1'($urandom));
                send_item(CMD_LOAD, pick_sample(), 1'b1);
                send_candidate(pick_cand_len(), 1'b1);
            end
            else
            begin
                // noise: any command, any last
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    send_item(1'($urandom), pick_sample(), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        int k;
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = CMD_LOAD;
        sample        = '0;
        last          = 1'b0;
        items_sent    = 0;
        send_idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, no idling ----
        // candidates before any query: ignored
        send_item(CMD_CAND, 16'sh7FFF, 1'b0);
        send_item(CMD_CAND, 16'sh8000, 1'b1);
        // one-sample query, extreme distance
        send_item(CMD_LOAD, 16'sh7FFF, 1'b1);
        send_item(CMD_CAND, 16'sh8000, 1'b1);
        // two-sample query of both extremes, three-sample candidate
        send_item(CMD_LOAD, 16'sh8000, 1'b0);
        send_item(CMD_LOAD, 16'sh7FFF, 1'b1);
        send_item(CMD_CAND, 16'sh0000, 1'b0);
        send_item(CMD_CAND, 16'sh8000, 1'b0);
        send_item(CMD_CAND, 16'sh7FFF, 1'b1);
        // query reload in the middle of a candidate
        send_item(CMD_CAND, 16'sh0001, 1'b0);
        send_item(CMD_CAND, 16'shFFFF, 1'b0);
        send_item(CMD_LOAD, 16'sh0000, 1'b0);
        send_item(CMD_LOAD, 16'sh0001, 1'b0);
        send_item(CMD_LOAD, 16'shFFFF, 1'b1);
        send_item(CMD_CAND, 16'sh5555, 1'b0);
        send_item(CMD_CAND, 16'shAAAA, 1'b1);
        // overlong query: samples past the row are dropped
        for (k = 0; k < MAX_LEN + 3; k++)
            send_item(CMD_LOAD, (k % 2) ? 16'sh7FFF : 16'sh8000, k == MAX_LEN + 2);
        send_item(CMD_CAND, 16'sh7FFF, 1'b0);
        send_item(CMD_CAND, 16'sh8000, 1'b1);
        wait_drained();

        // ---- random part, three phases, idling at 35, 57 and 0 percent ----
        send_idle_pct = 35;
        run_random(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 57;
        run_random(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 0;
        run_random(PHASE_ITEMS);

        // ---- end of run ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("tb_dtw_distance: %0d items taken, %0d distances checked", items_taken,
                 results_checked);
        $display("tb_dtw_distance: covered extremes, empty/overlong/reloaded queries, stalls");
        if (fail_count == 0)
            $display("tb_dtw_distance: done, clean");
        else
            $display("tb_dtw_distance: done, errors");
        $finish;
    end

endmodule
